// ===== rtl/fpu_mantissa_rounder_macros.svh =====
// Assertion macros shared by the rounder RTL.
// Each check samples on the rising edge of clk. FMR_ASSERT is muted while arst_n is low,
// and FMR_ASSERT_RST is also checked during reset.
`ifndef FPU_MANTISSA_ROUNDER_MACROS_SVH
`define FPU_MANTISSA_ROUNDER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FMR_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rounder check failed");

`define FMR_ASSERT_RST(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("rounder reset check failed");

`else

`define FMR_ASSERT(label, prop)

`define FMR_ASSERT_RST(label, prop)

`endif

`endif

// ===== rtl/fmr_pkg.sv =====
package fmr_pkg;

	localparam int unsigned MANT_W = 64;
	localparam int unsigned EXP_W  = 16;

	// Number of mantissa bits dropped below the boundary for the narrow precisions.
	localparam int unsigned SINGLE_DROP = 64 - 24;
	localparam int unsigned DOUBLE_DROP = 64 - 53;

	localparam logic [MANT_W-1:0] TOP_BIT = {1'b1, {(MANT_W-1){1'b0}}};

	// Configuration port.
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PREC = 1'd1;

	typedef enum logic [1:0] {
		RM_NEAREST_EVEN = 2'd0,
		RM_TOWARD_ZERO  = 2'd1,
		RM_TOWARD_MINUS = 2'd2,
		RM_TOWARD_PLUS  = 2'd3
	} rmode_t;

	typedef enum logic [1:0] {
		PREC_EXTENDED = 2'd0,
		PREC_SINGLE   = 2'd1,
		PREC_DOUBLE   = 2'd2,
		PREC_RESERVED = 2'd3
	} prec_t;

	typedef struct packed {
		rmode_t mode;
		prec_t  prec;
	} cfg_t;

	typedef struct packed {
		logic              in_sign;
		logic [EXP_W-1:0]  in_exponent;
		logic [MANT_W-1:0] in_mantissa;
		logic              in_guard;
		logic              in_round;
		logic              in_sticky;
	} in_word_t;

	typedef struct packed {
		logic              out_sign;
		logic [EXP_W-1:0]  out_exponent;
		logic [MANT_W-1:0] out_mantissa;
		logic              inexact;
	} out_word_t;

endpackage

// ===== rtl/fpu_mantissa_rounder.sv =====
// Rounding stage for an extended-precision floating-point datapath.
//
// The src channel carries one intermediate result per word: sign, 16-bit biased exponent,
// 64-bit mantissa with explicit integer bit, and guard, round and sticky bits. The dst
// channel returns the rounded sign, exponent, mantissa and the inexact flag, one word for
// every word accepted, in order. Both channels move a word on a rising edge where valid is
// high and stall is low.
//
// An accepted word is loaded into the input register, the rounding logic works on it, and
// the word then moves into the output register, which drives dst_valid and dst_word.
// Throughput is one word per cycle while dst does not stall; the 64-bit increment at the
// precision boundary between the two registers sets the cycle time.
// When dst stalls, the output register holds its word and the input register may still take
// one more word, so src_stall rises only once both registers are full.
//
// The rounding mode and precision registers are written through cfg_we, cfg_index and
// cfg_data; the user must change them only while no word is in flight, as the block does
// not enforce it. Reset sets both to nearest-even and extended precision, and empties the pipeline.
`include "fpu_mantissa_rounder_macros.svh"

module fpu_mantissa_rounder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fmr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fmr_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                               src_valid,
	output logic                               src_stall,
	input  fmr_pkg::in_word_t                  src_word,
	output logic                               dst_valid,
	input  logic                               dst_stall,
	output fmr_pkg::out_word_t                 dst_word
);

	fmr_pkg::cfg_t      cfg;
	fmr_pkg::in_word_t  word_s1;
	fmr_pkg::out_word_t word_s2;
	fmr_pkg::out_word_t rnd;
	logic               valid_s1;
	logic               valid_s2;
	logic               free_s1;
	logic               free_s2;

	fmr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// A stage can take a new word when it is empty or its word moves on this cycle.
	assign free_s2   = !valid_s2 || !dst_stall;
	assign free_s1   = !valid_s1 || free_s2;
	assign src_stall = !free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (free_s1) begin
				valid_s1 <= src_valid;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers load only when their stage advances, so a stalled word holds.
	always_ff @(posedge clk) begin
		if (free_s1 && src_valid) begin
			word_s1 <= src_word;
		end
		if (free_s2 && valid_s1) begin
			word_s2 <= rnd;
		end
	end

	fmr_round u_round (
		.cfg  (cfg),
		.din  (word_s1),
		.dout (rnd)
	);

	assign dst_valid = valid_s2;
	assign dst_word  = word_s2;

	`FMR_ASSERT_RST(a_reset_empty, !arst_n |-> !dst_valid)
	`FMR_ASSERT(a_full_backpressure, valid_s1 && valid_s2 && dst_stall |-> src_stall)
	`FMR_ASSERT(a_exact_passes, valid_s1 && !rnd.inexact |->
		rnd.out_mantissa == word_s1.in_mantissa)
	`FMR_ASSERT(a_exp_only_on_carry, valid_s1 && rnd.out_exponent != word_s1.in_exponent |->
		rnd.out_mantissa == fmr_pkg::TOP_BIT)
	`FMR_ASSERT(a_single_low_clear, valid_s1 && cfg.prec == fmr_pkg::PREC_SINGLE |->
		rnd.out_mantissa[fmr_pkg::SINGLE_DROP-1:0] == '0)

endmodule

// ===== rtl/fmr_cfg.sv =====
module fmr_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [fmr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fmr_pkg::CFG_DATA_W-1:0]     cfg_data,
	output fmr_pkg::cfg_t                      cfg
);

	fmr_pkg::rmode_t mode_q;
	fmr_pkg::prec_t  prec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= fmr_pkg::RM_NEAREST_EVEN;
			prec_q <= fmr_pkg::PREC_EXTENDED;
		end else if (cfg_we) begin
			case (cfg_index)
				fmr_pkg::REG_MODE: mode_q <= fmr_pkg::rmode_t'(cfg_data[1:0]);
				fmr_pkg::REG_PREC: prec_q <= fmr_pkg::prec_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	assign cfg.mode = mode_q;
	assign cfg.prec = prec_q;

endmodule

// ===== rtl/fmr_round.sv =====
module fmr_round (
	input  fmr_pkg::cfg_t     cfg,
	input  fmr_pkg::in_word_t din,
	output fmr_pkg::out_word_t dout
);

	localparam int unsigned MW = fmr_pkg::MANT_W;
	localparam int unsigned SD = fmr_pkg::SINGLE_DROP;
	localparam int unsigned DD = fmr_pkg::DOUBLE_DROP;

	logic [MW-1:0] mant_t;
	logic [MW-1:0] lsb;
	logic          g;
	logic          r;
	logic          s;
	logic          inc;
	logic          any_low;
	logic [MW:0]   sum;

	// Single/double fold the bits below the boundary into new guard, round, sticky bits.
	always_comb begin
		any_low = din.in_guard | din.in_round | din.in_sticky;
		case (cfg.prec)
			fmr_pkg::PREC_SINGLE: begin
				mant_t = {din.in_mantissa[MW-1:SD], {SD{1'b0}}};
				lsb    = {{(MW-SD-1){1'b0}}, 1'b1, {SD{1'b0}}};
				g      = din.in_mantissa[SD-1];
				r      = din.in_mantissa[SD-2];
				s      = (|din.in_mantissa[SD-3:0]) | any_low;
			end
			fmr_pkg::PREC_DOUBLE: begin
				mant_t = {din.in_mantissa[MW-1:DD], {DD{1'b0}}};
				lsb    = {{(MW-DD-1){1'b0}}, 1'b1, {DD{1'b0}}};
				g      = din.in_mantissa[DD-1];
				r      = din.in_mantissa[DD-2];
				s      = (|din.in_mantissa[DD-3:0]) | any_low;
			end
			default: begin
				mant_t = din.in_mantissa;
				lsb    = {{(MW-1){1'b0}}, 1'b1};
				g      = din.in_guard;
				r      = din.in_round;
				s      = din.in_sticky;
			end
		endcase
	end

	always_comb begin
		case (cfg.mode)
			fmr_pkg::RM_NEAREST_EVEN: inc = g & (r | s | (|(mant_t & lsb)));
			fmr_pkg::RM_TOWARD_MINUS: inc = din.in_sign;
			fmr_pkg::RM_TOWARD_PLUS:  inc = ~din.in_sign;
			default:                  inc = 1'b0;
		endcase
	end

	assign sum = {1'b0, mant_t} + {1'b0, lsb};

	always_comb begin
		dout.out_sign     = din.in_sign;
		dout.inexact      = g | r | s;
		dout.out_exponent = din.in_exponent;
		dout.out_mantissa = mant_t;
		if ((g | r | s) && inc) begin
			if (sum[MW]) begin
				// Carry out of the mantissa: renormalize and bump the exponent.
				dout.out_mantissa = {1'b1, sum[MW-1:1]};
				dout.out_exponent = din.in_exponent + fmr_pkg::EXP_W'(1);
			end else begin
				dout.out_mantissa = sum[MW-1:0];
			end
		end
	end

endmodule
